// ----- src/tga_rle_image_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// TGA RLE image decoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH

// same-cycle implication
`define TGADEC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tgadec assertion failed");

// next-cycle implication
`define TGADEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tgadec assertion failed");

`endif

// ----- src/tgadec_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA RLE image decoder package
// Shared constants, status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tgadec_pkg;

    localparam int PIXEL_COUNT_BITS_DEF = 32;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_TYPE   = 3'd1;
    localparam logic [2:0] ST_HEADER = 3'd2;
    localparam logic [2:0] ST_MANY   = 3'd3;
    localparam logic [2:0] ST_TRUNC  = 3'd4;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] BPP_24   = 8'd24;
    localparam logic [7:0] BPP_32   = 8'd32;

    // header byte offsets
    localparam logic [4:0] OFS_TYPE     = 5'd2;
    localparam logic [4:0] OFS_WIDTH_LO = 5'd12;
    localparam logic [4:0] OFS_WIDTH_HI = 5'd13;
    localparam logic [4:0] OFS_HGT_LO   = 5'd14;
    localparam logic [4:0] OFS_HGT_HI   = 5'd15;
    localparam logic [4:0] OFS_BPP      = 5'd16;
    localparam logic [4:0] OFS_DESC     = 5'd17;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       alpha_present;
        logic [7:0] repeat_count;
        logic       image_done;
        logic [2:0] status;
    } result_t;

endpackage

`default_nettype wire

// ----- src/tgadec_core.sv -----
// ----------------------------------------------------------------------------
// TGA decoder core
// Header parser and packet/pixel decoder, consuming one byte per accepted input.
// ----------------------------------------------------------------------------
`default_nettype none

module tgadec_core
    import tgadec_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_acc,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            res_valid,
    output result_t         res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PACKET = 2'd1;
    localparam logic [1:0] PH_PIXEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam int PCB = PIXEL_COUNT_BITS;

    logic [1:0]     phase_reg, phase_next;
    logic [4:0]     pos_reg, pos_next;
    logic           rle_reg, rle_next;
    logic [15:0]    width_reg, width_next;
    logic [15:0]    height_reg, height_next;
    logic           four_reg, four_next;
    logic [7:0]     bpp_reg, bpp_next;
    logic [31:0]    prod_reg, prod_next;
    logic [PCB-1:0] pix_left_reg, pix_left_next;
    logic [7:0]     pkt_left_reg, pkt_left_next;
    logic           run_reg, run_next;
    logic [31:0]    colour_reg, colour_next;

    logic [7:0]     len;
    logic [31:0]    col_b;
    logic [1:0]     bpos;
    logic           last_byte;
    logic [7:0]     count;
    logic [PCB-1:0] count_ext;
    logic           err;
    logic [2:0]     err_code;
    logic           pix_out;

    assign len  = {1'b0, in_byte[6:0]} + 8'd1;
    assign bpos = pos_reg[1:0];

    always_comb begin
        col_b = colour_reg;
        case (bpos)
            2'd0:    col_b[7:0]   = in_byte;
            2'd1:    col_b[15:8]  = in_byte;
            2'd2:    col_b[23:16] = in_byte;
            default: col_b[31:24] = in_byte;
        endcase
    end

    assign last_byte = four_reg ? (bpos == 2'd3) : (bpos == 2'd2);
    assign count     = (rle_reg && run_reg) ? pkt_left_reg : 8'd1;
    assign count_ext = {{(PCB-8){1'b0}}, count};

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        rle_next      = rle_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        four_next     = four_reg;
        bpp_next      = bpp_reg;
        prod_next     = prod_reg;
        pix_left_next = pix_left_reg;
        pkt_left_next = pkt_left_reg;
        run_next      = run_reg;
        colour_next   = colour_reg;
        err           = 1'b0;
        err_code      = ST_OK;
        pix_out       = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        case (phase_reg)
            PH_HEADER: begin
                case (pos_reg)
                    OFS_TYPE: begin
                        if (in_byte == TYPE_RAW) begin
                            rle_next = 1'b0;
                        end else if (in_byte == TYPE_RLE) begin
                            rle_next = 1'b1;
                        end else begin
                            err        = 1'b1;
                            err_code   = ST_TYPE;
                            phase_next = PH_DONE;
                        end
                    end
                    OFS_WIDTH_LO: width_next  = {8'd0, in_byte};
                    OFS_WIDTH_HI: width_next  = {in_byte, width_reg[7:0]};
                    OFS_HGT_LO:   height_next = {8'd0, in_byte};
                    OFS_HGT_HI:   height_next = {in_byte, height_reg[7:0]};
                    OFS_BPP: begin
                        four_next = (in_byte == BPP_32);
                        bpp_next  = in_byte;
                        prod_next = {16'd0, width_reg} * {16'd0, height_reg};
                    end
                    OFS_DESC: begin
                        bpp_next = 8'd0;
                        if (prod_reg == 32'd0 || (bpp_reg != BPP_24 && bpp_reg != BPP_32)
                                || (prod_reg >> PCB) != 32'd0) begin
                            four_next  = 1'b0;
                            err        = 1'b1;
                            err_code   = ST_HEADER;
                            phase_next = PH_DONE;
                        end else begin
                            pix_left_next = prod_reg[PCB-1:0];
                            phase_next    = rle_reg ? PH_PACKET : PH_PIXEL;
                        end
                    end
                    default: ;
                endcase
                pos_next = (phase_next == PH_HEADER) ? pos_reg + 5'd1 : 5'd0;
            end
            PH_PACKET: begin
                if ({{(PCB-8){1'b0}}, len} > pix_left_reg) begin
                    err        = 1'b1;
                    err_code   = ST_MANY;
                    phase_next = PH_DONE;
                end else begin
                    pkt_left_next = len;
                    run_next      = in_byte[7];
                    pos_next      = 5'd0;
                    colour_next   = 32'd0;
                    phase_next    = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (last_byte) begin
                    pix_out  = 1'b1;
                    pos_next = 5'd0;
                    if (rle_reg && run_reg) begin
                        pkt_left_next = 8'd0;
                    end else if (pkt_left_reg != 8'd0) begin
                        pkt_left_next = pkt_left_reg - 8'd1;
                    end
                    if (count_ext > pix_left_reg) begin
                        pix_left_next = '0;
                    end else begin
                        pix_left_next = pix_left_reg - count_ext;
                    end
                    colour_next = 32'd0;
                    if (pix_left_next == '0) begin
                        phase_next = PH_DONE;
                    end else if (rle_reg && pkt_left_next == 8'd0) begin
                        phase_next = PH_PACKET;
                    end
                end else begin
                    colour_next = col_b;
                    pos_next    = {3'd0, bpos + 2'd1};
                end
            end
            default: ;
        endcase

        if (in_last && phase_next != PH_DONE && !err) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
        end

        if (err) begin
            res_valid         = in_acc;
            res.alpha_present = four_next;
            res.image_done    = 1'b1;
            res.status        = err_code;
        end else if (pix_out) begin
            res_valid         = in_acc;
            res.red           = col_b[23:16];
            res.green         = col_b[15:8];
            res.blue          = col_b[7:0];
            res.alpha         = four_reg ? col_b[31:24] : 8'd0;
            res.alpha_present = four_reg;
            res.repeat_count  = count;
            res.image_done    = (pix_left_next == '0);
            res.status        = ST_OK;
        end

        if (in_last) begin
            phase_next    = PH_HEADER;
            pos_next      = 5'd0;
            rle_next      = 1'b0;
            width_next    = 16'd0;
            height_next   = 16'd0;
            four_next     = 1'b0;
            bpp_next      = 8'd0;
            pix_left_next = '0;
            pkt_left_next = 8'd0;
            run_next      = 1'b0;
            colour_next   = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= 5'd0;
            rle_reg      <= 1'b0;
            width_reg    <= 16'd0;
            height_reg   <= 16'd0;
            four_reg     <= 1'b0;
            bpp_reg      <= 8'd0;
            pix_left_reg <= '0;
            pkt_left_reg <= 8'd0;
            run_reg      <= 1'b0;
            colour_reg   <= 32'd0;
        end else if (in_acc) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            rle_reg      <= rle_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            four_reg     <= four_next;
            bpp_reg      <= bpp_next;
            pix_left_reg <= pix_left_next;
            pkt_left_reg <= pkt_left_next;
            run_reg      <= run_next;
            colour_reg   <= colour_next;
        end
    end

    // pixel count product, only consumed at the descriptor byte
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tga_rle_image_decoder.sv -----
// ----------------------------------------------------------------------------
// TGA RLE image decoder
// Streams a type 2 or type 10 TGA file and emits pixels and run lengths.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while s_tready is high. Each byte goes
// through a single step of parser logic into the result register, so a result
// appears in the cycle after its byte. A byte is taken in every cycle unless a
// result is waiting in the result register and m_tready is low; a result taken
// and a new one loaded in the same cycle cost no gap. The width*height product
// is formed in its own register on the bits-per-pixel byte and checked on the
// following byte. A repeat packet comes out as one item with its run length;
// errors come out as a last item with a non-zero status. s_tlast closes a file;
// the next byte starts a new header.
`default_nettype none
`include "tga_rle_image_decoder_macros.svh"

module tga_rle_image_decoder
    import tgadec_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // red, green, blue, alpha, repeat_count
    output logic             m_tlast,   // image_done
    output logic [3:0]       m_tuser    // alpha_present, status[2:0]
);

    logic    s_acc;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg;
    result_t m_res_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    tgadec_core #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_acc    (s_acc),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.repeat_count, m_res_reg.alpha, m_res_reg.blue,
                       m_res_reg.green, m_res_reg.red};
    assign m_tlast  = m_res_reg.image_done;
    assign m_tuser  = {m_res_reg.status, m_res_reg.alpha_present};

    `TGADEC_ASSERT_NOW(a_err_is_last, aclk, aresetn, m_valid_reg && m_res_reg.status != ST_OK, m_res_reg.image_done && m_res_reg.repeat_count == 8'd0)
    `TGADEC_ASSERT_NOW(a_ok_has_count, aclk, aresetn, m_valid_reg && m_res_reg.status == ST_OK, m_res_reg.repeat_count != 8'd0)
    `TGADEC_ASSERT_NEXT(a_result_lands, aclk, aresetn, s_acc && res_valid, m_valid_reg)

endmodule

`default_nettype wire

// ----- tb/tb_tga_rle_image_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE image decoder testbench
// Feeds whole and broken TGA files byte by byte with random gaps on both
// streams. A local decoder works out the pixel and error items that each
// accepted byte should cause, and every item leaving the block is checked
// field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tb_tga_rle_image_decoder;
    import tgadec_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1230;

    typedef enum logic [2:0] {PH_HEADER, PH_PACKET, PH_PIXEL, PH_DONE} dec_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic        s_tlast;   // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // red, green, blue, alpha, repeat_count
    logic        m_tlast;   // image_done
    logic [3:0]  m_tuser;   // alpha_present, status[2:0]

    tga_rle_image_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // local decoder state
    dec_phase_t  dec_phase;
    logic [4:0]  hdr_pos;
    logic        rle_mode;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        four_bpp;
    logic [31:0] pixels_left;
    logic [7:0]  packet_left;
    logic        packet_is_run;
    logic [31:0] colour_bytes;

    result_t    pixel_q[$];
    logic [7:0] file_bytes[$];
    int         error_count = 0;
    int         bytes_taken = 0;
    int         cycle_count = 0;
    bit         idle_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_decoder();
        dec_phase     = PH_HEADER;
        hdr_pos       = '0;
        rle_mode      = 1'b0;
        img_w         = '0;
        img_h         = '0;
        four_bpp      = 1'b0;
        pixels_left   = '0;
        packet_left   = '0;
        packet_is_run = 1'b0;
        colour_bytes  = '0;
    endfunction

    function automatic result_t error_item(logic [2:0] code);
        result_t r;
        r               = '0;
        r.alpha_present = four_bpp;
        r.image_done    = 1'b1;
        r.status        = code;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        result_t     r;
        logic        have;
        logic        err;
        logic [63:0] cnt;
        logic [8:0]  len;
        logic [7:0]  count;
        logic [7:0]  bpp;
        int          pp;
        int          need;
        have = 1'b0;
        err  = 1'b0;
        r    = '0;
        case (dec_phase)
            PH_HEADER: begin
                case (hdr_pos)
                    OFS_TYPE: begin
                        if (b == TYPE_RAW) begin
                            rle_mode = 1'b0;
                        end else if (b == TYPE_RLE) begin
                            rle_mode = 1'b1;
                        end else begin
                            r = error_item(ST_TYPE);
                            have = 1'b1;
                            err = 1'b1;
                            dec_phase = PH_DONE;
                        end
                    end
                    OFS_WIDTH_LO: img_w = {8'd0, b};
                    OFS_WIDTH_HI: img_w[15:8] = b;
                    OFS_HGT_LO:   img_h = {8'd0, b};
                    OFS_HGT_HI:   img_h[15:8] = b;
                    OFS_BPP: begin
                        four_bpp = (b == BPP_32);
                        colour_bytes = {24'd0, b};
                    end
                    OFS_DESC: begin
                        bpp = colour_bytes[7:0];
                        cnt = 64'(img_w) * 64'(img_h);
                        colour_bytes = '0;
                        if (img_w == 0 || img_h == 0 || (bpp != BPP_24 && bpp != BPP_32) ||
                            cnt > ((64'd1 << PIXEL_COUNT_BITS_DEF) - 64'd1)) begin
                            four_bpp = 1'b0;
                            r = error_item(ST_HEADER);
                            have = 1'b1;
                            err = 1'b1;
                            dec_phase = PH_DONE;
                        end else begin
                            pixels_left = cnt[31:0];
                            dec_phase = rle_mode ? PH_PACKET : PH_PIXEL;
                        end
                    end
                    default: ;
                endcase
                if (dec_phase == PH_HEADER) hdr_pos = hdr_pos + 5'd1;
                else hdr_pos = '0;
            end
            PH_PACKET: begin
                len = (b < 8'd128) ? {1'b0, b} + 9'd1 : {1'b0, b} - 9'd127;
                if (32'(len) > pixels_left) begin
                    r = error_item(ST_MANY);
                    have = 1'b1;
                    err = 1'b1;
                    dec_phase = PH_DONE;
                end else begin
                    packet_left   = len[7:0];
                    packet_is_run = (b >= 8'd128);
                    hdr_pos       = '0;
                    colour_bytes  = '0;
                    dec_phase     = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                need = four_bpp ? 4 : 3;
                pp = int'(hdr_pos[1:0]);
                colour_bytes = colour_bytes | (32'(b) << (8 * pp));
                pp++;
                if (pp >= need) begin
                    hdr_pos = '0;
                    if (rle_mode && packet_is_run) begin
                        count = packet_left;
                        packet_left = '0;
                    end else begin
                        count = 8'd1;
                        if (packet_left > 0) packet_left--;
                    end
                    if (32'(count) > pixels_left) pixels_left = '0;
                    else pixels_left = pixels_left - 32'(count);
                    r.red           = colour_bytes[23:16];
                    r.green         = colour_bytes[15:8];
                    r.blue          = colour_bytes[7:0];
                    r.alpha         = four_bpp ? colour_bytes[31:24] : 8'd0;
                    r.alpha_present = four_bpp;
                    r.repeat_count  = count;
                    r.image_done    = (pixels_left == 0);
                    r.status        = ST_OK;
                    have = 1'b1;
                    colour_bytes = '0;
                    if (pixels_left == 0) dec_phase = PH_DONE;
                    else if (rle_mode && packet_left == 0) dec_phase = PH_PACKET;
                end else begin
                    hdr_pos = 5'(pp);
                end
            end
            default: ;
        endcase
        if (fin) begin
            if (dec_phase != PH_DONE && !err) begin
                r = error_item(ST_TRUNC);
                have = 1'b1;
            end
            clear_decoder();
        end
        if (have) pixel_q.push_back(r);
    endtask

    // monitor: output items checked, accepted input bytes decoded
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                if (m_tvalid && m_tready) begin
                    if (pixel_q.size() == 0) begin
                        $error("unexpected item: tdata %h tlast %b tuser %h",
                               m_tdata, m_tlast, m_tuser);
                        error_count++;
                    end else begin
                        want = pixel_q.pop_front();
                        if (m_tdata[7:0] !== want.red) begin
                            $error("red: expected %0d, got %0d", want.red, m_tdata[7:0]);
                            error_count++;
                        end
                        if (m_tdata[15:8] !== want.green) begin
                            $error("green: expected %0d, got %0d", want.green, m_tdata[15:8]);
                            error_count++;
                        end
                        if (m_tdata[23:16] !== want.blue) begin
                            $error("blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                            error_count++;
                        end
                        if (m_tdata[31:24] !== want.alpha) begin
                            $error("alpha: expected %0d, got %0d", want.alpha, m_tdata[31:24]);
                            error_count++;
                        end
                        if (m_tdata[39:32] !== want.repeat_count) begin
                            $error("repeat_count: expected %0d, got %0d",
                                   want.repeat_count, m_tdata[39:32]);
                            error_count++;
                        end
                        if (m_tlast !== want.image_done) begin
                            $error("image_done: expected %0d, got %0d", want.image_done, m_tlast);
                            error_count++;
                        end
                        if (m_tuser[0] !== want.alpha_present) begin
                            $error("alpha_present: expected %0d, got %0d",
                                   want.alpha_present, m_tuser[0]);
                            error_count++;
                        end
                        if (m_tuser[3:1] !== want.status) begin
                            $error("status: expected %0d, got %0d", want.status, m_tuser[3:1]);
                            error_count++;
                        end
                    end
                end
                if (s_tvalid && s_tready) begin
                    decode_byte(s_tdata, s_tlast);
                    bytes_taken++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int target;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = fin;
        target   = bytes_taken + 1;
        do @(negedge aclk); while (bytes_taken != target);
    endtask

    // sends file_bytes[0..stop] as one file, tlast on the last
    task automatic send_file(input int stop);
        for (int i = 0; i <= stop; i++) send_byte(file_bytes[i], i == stop);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
    endtask

    task automatic put_header(input logic [7:0] ty, input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] bpp);
        logic [7:0] hb;
        file_bytes.delete();
        for (int i = 0; i < 18; i++) begin
            hb = 8'($urandom);
            if (i == OFS_TYPE) hb = ty;
            else if (i == OFS_WIDTH_LO) hb = w[7:0];
            else if (i == OFS_WIDTH_HI) hb = w[15:8];
            else if (i == OFS_HGT_LO) hb = h[7:0];
            else if (i == OFS_HGT_HI) hb = h[15:8];
            else if (i == OFS_BPP) hb = bpp;
            file_bytes.push_back(hb);
        end
    endtask

    task automatic put_pixel(input logic [31:0] v, input bit quad);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
        file_bytes.push_back(v[23:16]);
        if (quad) file_bytes.push_back(v[31:24]);
    endtask

    task automatic put_packet(input bit run, input int len, input bit quad);
        file_bytes.push_back(run ? 8'(127 + len) : 8'(len - 1));
        repeat (run ? 1 : len) put_pixel($urandom, quad);
    endtask

    task automatic put_image_data(input bit rle, input int count, input bit quad);
        int left;
        int len;
        left = count;
        if (!rle) begin
            repeat (count) put_pixel($urandom, quad);
        end else begin
            while (left > 0) begin
                len = $urandom_range(1, (left < 128) ? left : 128);
                put_packet($urandom_range(0, 1), len, quad);
                left -= len;
            end
        end
    endtask

    task automatic test_raw_images();
        put_header(TYPE_RAW, 16'd2, 16'd1, BPP_24);
        put_pixel(32'h0000_0000, 1'b0);
        put_pixel(32'hFFFF_FFFF, 1'b0);
        send_file(file_bytes.size() - 1);
        put_header(TYPE_RAW, 16'd1, 16'd1, BPP_32);
        put_pixel(32'hFFFF_FFFF, 1'b1);
        send_file(file_bytes.size() - 1);
    endtask

    task automatic test_rle_images();
        // longest run
        put_header(TYPE_RLE, 16'd128, 16'd1, BPP_32);
        put_packet(1'b1, 128, 1'b1);
        send_file(file_bytes.size() - 1);
        // raw then run, then a byte after the image that must be ignored
        put_header(TYPE_RLE, 16'd3, 16'd1, BPP_32);
        put_packet(1'b0, 1, 1'b1);
        put_packet(1'b1, 2, 1'b1);
        file_bytes.push_back(8'h55);
        send_file(file_bytes.size() - 1);
    endtask

    task automatic test_header_errors();
        // bad type, tlast on the same byte
        put_header(8'h00, 16'd1, 16'd1, BPP_24);
        send_file(OFS_TYPE);
        put_header(8'hFF, 16'd1, 16'd1, BPP_24);
        put_pixel($urandom, 1'b0);
        send_file(file_bytes.size() - 1);
        put_header(TYPE_RAW, 16'd0, 16'd5, BPP_24);
        send_file(OFS_DESC);
        put_header(TYPE_RLE, 16'd5, 16'd0, BPP_32);
        send_file(OFS_DESC);
        put_header(TYPE_RAW, 16'd1, 16'd1, 8'd16);
        send_file(OFS_DESC);
    endtask

    task automatic test_overrun();
        put_header(TYPE_RLE, 16'd1, 16'd1, BPP_24);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'hA5);
        send_file(file_bytes.size() - 1);
        put_header(TYPE_RLE, 16'd1, 16'd2, BPP_32);
        file_bytes.push_back(8'h82);
        send_file(file_bytes.size() - 1);
    endtask

    task automatic test_truncation();
        int cuts[5];
        cuts = '{5, 16, 17, 18, 21};
        put_header(TYPE_RLE, 16'd1, 16'd2, BPP_24);
        put_packet(1'b0, 2, 1'b0);
        // mid header, on bpp, on descriptor, on packet byte, on a completed pixel
        foreach (cuts[i]) send_file(cuts[i]);
        send_file(20);
    endtask

    task automatic test_random_files();
        int         sent;
        int         kind;
        int         w;
        int         h;
        int         left;
        int         len;
        int         stop;
        bit         rle;
        bit         quad;
        logic [7:0] ty;
        logic [7:0] bpp;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if (sent > RANDOM_BYTES - 250) idle_on = 1'b0;
            kind = $urandom_range(0, 9);
            rle  = $urandom_range(0, 1);
            quad = $urandom_range(0, 1);
            w    = $urandom_range(1, 4);
            h    = $urandom_range(1, 3);
            bpp  = quad ? BPP_32 : BPP_24;
            ty   = rle ? TYPE_RLE : TYPE_RAW;
            if (kind <= 6) begin
                put_header(ty, 16'(w), 16'(h), bpp);
                put_image_data(rle, w * h, quad);
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
                end
                stop = file_bytes.size() - 1;
            end else if (kind == 7) begin
                // cut anywhere, sometimes in a huge image
                if ($urandom_range(0, 1) == 1) begin
                    w = $urandom_range(1, 65535);
                    h = $urandom_range(1, 65535);
                end
                put_header(ty, 16'(w), 16'(h), bpp);
                repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
                stop = $urandom_range(0, file_bytes.size() - 1);
            end else if (kind == 8) begin
                case ($urandom_range(0, 3))
                    0: w = 0;
                    1: h = 0;
                    2: bpp = 8'($urandom);
                    default: begin
                        ty  = 8'($urandom);
                        w   = $urandom_range(0, 65535);
                        h   = $urandom_range(0, 65535);
                        bpp = 8'($urandom);
                    end
                endcase
                put_header(ty, 16'(w), 16'(h), bpp);
                repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
                stop = file_bytes.size() - 1;
            end else begin
                left = w * h;
                put_header(TYPE_RLE, 16'(w), 16'(h), bpp);
                while (left > 1 && $urandom_range(0, 1) == 1) begin
                    len = $urandom_range(1, left - 1);
                    put_packet($urandom_range(0, 1), len, quad);
                    left -= len;
                end
                len = $urandom_range(left + 1, 128);
                file_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'(127 + len) : 8'(len - 1));
                repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
                stop = file_bytes.size() - 1;
            end
            send_file(stop);
            sent += stop + 1;
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        clear_decoder();
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_raw_images();
        test_rle_images();
        test_header_errors();
        test_overrun();
        test_truncation();
        test_random_files();

        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/tgadec_pkg.sv
src/tgadec_core.sv
src/tga_rle_image_decoder.sv
tb/tb_tga_rle_image_decoder.sv
